// File: rtl/core/bounded_array_list_insert_delete_top_macros.svh
// ----------------------------------------------------------------------------
// bounded array list assertion macros
// shared concurrent assertion forms, clocked on clk, off during rst
// ----------------------------------------------------------------------------
`ifndef BOUNDED_ARRAY_LIST_INSERT_DELETE_TOP_MACROS_SVH
`define BOUNDED_ARRAY_LIST_INSERT_DELETE_TOP_MACROS_SVH

// same-cycle implication
`define BALI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BALI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/bali_pkg.sv
// ----------------------------------------------------------------------------
// bali_pkg
// types and constants shared by the bounded array list cells and control
// ----------------------------------------------------------------------------
`default_nettype none

package bali_pkg;

  localparam int DEPTH       = 64;
  localparam int ENTRY_WIDTH = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int CAP_W       = 7;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [1:0] {
    OP_READ   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_INSERT = 2'd2,
    OP_DELETE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // broadcast to every cell
  typedef struct packed {
    logic                   wr;
    logic                   ins;
    logic                   del;
    logic [IDX_W-1:0]       idx;
    logic [ENTRY_WIDTH-1:0] val;
  } cell_ctl_t;

  typedef struct packed {
    status_t          status;
    logic             rd_ok;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/core/bali_cell.sv
// ----------------------------------------------------------------------------
// bali_cell
// one list slot: write, take from lower neighbor on insert, from upper on delete
// ----------------------------------------------------------------------------
`default_nettype none

module bali_cell (
  input  logic                            clk,
  input  bali_pkg::cell_ctl_t             ctl,
  input  logic [bali_pkg::IDX_W-1:0]      my_idx,
  input  logic [bali_pkg::IDX_W-1:0]      rd_pos,
  input  logic [bali_pkg::ENTRY_WIDTH-1:0] lower_q,
  input  logic [bali_pkg::ENTRY_WIDTH-1:0] upper_q,
  output logic [bali_pkg::ENTRY_WIDTH-1:0] q,
  output logic [bali_pkg::ENTRY_WIDTH-1:0] tap
);

  always_ff @(posedge clk) begin
    if (ctl.wr && (my_idx == ctl.idx)) begin
      q <= ctl.val;
    end else if (ctl.ins && (my_idx > ctl.idx)) begin
      q <= lower_q;
    end else if (ctl.del && (my_idx >= ctl.idx)) begin
      q <= upper_q;
    end
  end

  // only the addressed slot drives the read bus
  assign tap = (my_idx == rd_pos) ? q : '0;

endmodule

`default_nettype wire

// File: rtl/core/bali_ctrl.sv
// ----------------------------------------------------------------------------
// bali_ctrl
// live count, status decision and the command broadcast to the cell row
// ----------------------------------------------------------------------------
`default_nettype none

module bali_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             accept,
  input  logic [1:0]                       operation,
  input  logic [bali_pkg::IDX_W-1:0]       position,
  input  logic [bali_pkg::ENTRY_WIDTH-1:0] entry_value,
  input  logic [bali_pkg::CAP_W-1:0]       cap,
  output bali_pkg::cell_ctl_t              ctl,
  output bali_pkg::result_t                res
);

  logic [bali_pkg::CNT_W-1:0] count;
  logic [bali_pkg::CNT_W-1:0] count_next;
  logic [bali_pkg::CMP_W-1:0] cap_ext;
  logic [bali_pkg::CMP_W-1:0] cap_eff;
  logic [bali_pkg::CMP_W-1:0] cnt_ext;
  logic [bali_pkg::CNT_W-1:0] pos_ext;
  logic                       full;
  logic                       in_range;
  bali_pkg::op_t              op;

  assign op       = bali_pkg::op_t'(operation);
  assign cap_ext  = bali_pkg::CMP_W'(cap);
  assign cnt_ext  = bali_pkg::CMP_W'(count);
  assign cap_eff  = (cap_ext > bali_pkg::CMP_W'(bali_pkg::DEPTH)) ?
                    bali_pkg::CMP_W'(bali_pkg::DEPTH) : cap_ext;
  assign full     = (cnt_ext >= cap_eff);
  assign pos_ext  = bali_pkg::CNT_W'(position);
  assign in_range = (pos_ext < count);

  always_comb begin
    ctl        = '0;
    ctl.val    = entry_value;
    ctl.idx    = position;
    res        = '0;
    res.status = bali_pkg::ST_OK;
    count_next = count;
    case (op)
      bali_pkg::OP_READ: begin
        if (!in_range) begin
          res.status = bali_pkg::ST_RANGE;
        end else begin
          res.rd_ok = 1'b1;
        end
      end
      bali_pkg::OP_PUSH: begin
        if (full) begin
          res.status = bali_pkg::ST_FULL;
        end else begin
          // count is below capacity here, so it fits an index
          ctl.wr     = accept;
          ctl.idx    = bali_pkg::IDX_W'(count);
          count_next = count + 1'b1;
        end
      end
      bali_pkg::OP_INSERT: begin
        if (full) begin
          res.status = bali_pkg::ST_FULL;
        end else if (!in_range) begin
          res.status = bali_pkg::ST_RANGE;
        end else begin
          ctl.wr     = accept;
          ctl.ins    = accept;
          count_next = count + 1'b1;
        end
      end
      bali_pkg::OP_DELETE: begin
        if (count == '0) begin
          res.status = bali_pkg::ST_EMPTY;
        end else if (!in_range) begin
          res.status = bali_pkg::ST_RANGE;
        end else begin
          ctl.del    = accept;
          count_next = count - 1'b1;
        end
      end
      default: begin
        res.status = bali_pkg::ST_OK;
      end
    endcase
    res.count = count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bounded_array_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// bounded_array_list_insert_delete_top
// ordered list in a row of shifting cells: read, push, insert, delete
// outputs registered: output valid rises in the cycle after input accept
// throughput: one item per cycle while the output is not stalled; the whole cell row shifts at once
// reset: clears the count and the output valid flag, capacity back to 64
// entries are not cleared; only slots below the count are ever read
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_array_list_insert_delete_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [bali_pkg::CAP_W-1:0]       cfg_wr_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       operation,
  input  logic [bali_pkg::IDX_W-1:0]       position,
  input  logic [bali_pkg::ENTRY_WIDTH-1:0] entry_value,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [bali_pkg::ENTRY_WIDTH-1:0] read_value,
  output logic [1:0]                       status,
  output logic [bali_pkg::CNT_W-1:0]       entry_count
);

  logic [bali_pkg::CAP_W-1:0]       cap;
  logic                             accept;
  bali_pkg::cell_ctl_t              ctl;
  bali_pkg::result_t                res;
  logic [bali_pkg::ENTRY_WIDTH-1:0] cell_q   [bali_pkg::DEPTH];
  logic [bali_pkg::ENTRY_WIDTH-1:0] cell_tap [bali_pkg::DEPTH];
  logic [bali_pkg::ENTRY_WIDTH-1:0] rd_bus;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= bali_pkg::CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cfg_wr_data;
    end
  end

  bali_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .operation   (operation),
    .position    (position),
    .entry_value (entry_value),
    .cap         (cap),
    .ctl         (ctl),
    .res         (res)
  );

  for (genvar i = 0; i < bali_pkg::DEPTH; i++) begin : g_cell
    logic [bali_pkg::ENTRY_WIDTH-1:0] lower_q;
    logic [bali_pkg::ENTRY_WIDTH-1:0] upper_q;

    if (i == 0) begin : g_first
      assign lower_q = '0;
    end else begin : g_lower
      assign lower_q = cell_q[i-1];
    end

    if (i == bali_pkg::DEPTH - 1) begin : g_last
      assign upper_q = '0;
    end else begin : g_upper
      assign upper_q = cell_q[i+1];
    end

    bali_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .my_idx  (bali_pkg::IDX_W'(i)),
      .rd_pos  (position),
      .lower_q (lower_q),
      .upper_q (upper_q),
      .q       (cell_q[i]),
      .tap     (cell_tap[i])
    );
  end

  always_comb begin
    rd_bus = '0;
    for (int k = 0; k < bali_pkg::DEPTH; k++) begin
      rd_bus = rd_bus | cell_tap[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value  <= res.rd_ok ? rd_bus : '0;
      status      <= res.status;
      entry_count <= res.count;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/bali_chk.sv
// ----------------------------------------------------------------------------
// bali_chk
// port-level checks on the bounded array list, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "bounded_array_list_insert_delete_top_macros.svh"

module bali_chk (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [bali_pkg::ENTRY_WIDTH-1:0] read_value,
  input logic [1:0]                       status,
  input logic [bali_pkg::CNT_W-1:0]       entry_count
);

  `BALI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_value) && $stable(status) && $stable(entry_count), "stalled item changed")
  `BALI_ASSERT_NEXT(a_accept_out, in_valid && in_ready, out_valid, "accepted item gave no result")
  `BALI_ASSERT_NOW(a_count_max, out_valid, entry_count <= bali_pkg::CNT_W'(bali_pkg::DEPTH), "count above depth")
  `BALI_ASSERT_NOW(a_rd_zero, out_valid && (read_value != '0), status == bali_pkg::ST_OK, "read value on a failed item")
  `BALI_ASSERT_NOW(a_empty_cnt, out_valid && (status == bali_pkg::ST_EMPTY), entry_count == '0, "empty with entries held")

endmodule

bind bounded_array_list_insert_delete_top bali_chk u_bali_chk (.*);

`default_nettype wire

// File: tb/sv/bounded_array_list_insert_delete_top_test.sv
// ----------------------------------------------------------------------------
// bounded_array_list_insert_delete_top_test
// A scheduled stream of reads, pushes, inserts and deletes runs against the
// list, with capacity changes between phases and random stalls on both
// channels. Every result is checked against a software copy of the list.
// ----------------------------------------------------------------------------

module bounded_array_list_insert_delete_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bali_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 40;
  localparam int SETTLE      = 3;

  typedef enum logic [2:0] {
    EV_ITEM,
    EV_CFG,
    EV_MODE,
    EV_HOLD,
    EV_DRAIN
  } sched_kind_t;

  typedef struct packed {
    sched_kind_t            kind;
    op_t                    op;
    logic [IDX_W-1:0]       pos;
    logic [ENTRY_WIDTH-1:0] val;
    logic [CAP_W-1:0]       cap;
    logic [6:0]             send_pct;
    logic [6:0]             recv_pct;
  } sched_entry_t;

  typedef struct {
    logic [ENTRY_WIDTH-1:0] mem [DEPTH];
    int unsigned            len;
    logic [CAP_W-1:0]       cap;
  } list_state_t;

  typedef struct packed {
    logic [ENTRY_WIDTH-1:0] read_value;
    status_t                status;
    logic [CNT_W-1:0]       entry_count;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CAP_W-1:0]       cfg_wr_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [1:0]             operation = '0;
  logic [IDX_W-1:0]       position = '0;
  logic [ENTRY_WIDTH-1:0] entry_value = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [ENTRY_WIDTH-1:0] read_value;
  logic [1:0]             status;
  logic [CNT_W-1:0]       entry_count;

  sched_entry_t op_schedule [$];
  list_result_t awaited_results [$];
  list_state_t  plan_list;
  list_state_t  live_list;

  logic item_taken = 1'b0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_reqs = 0;
  int   hold_seen = 0;
  int   hold_left = 0;
  int   settle_left = SETTLE;
  int   cycle_count = 0;
  int   mismatch_count = 0;
  int   cfg_writes = 0;
  int   peak_len = 0;
  int   ops_seen [4] = '{default: 0};
  int   status_seen [4] = '{default: 0};

  bounded_array_list_insert_delete_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .position    (position),
    .entry_value (entry_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .read_value  (read_value),
    .status      (status),
    .entry_count (entry_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // applies one operation to a list copy and returns the result it gives
  function automatic list_result_t apply_list_op(inout list_state_t s, input op_t op,
                                                 input logic [IDX_W-1:0] pos,
                                                 input logic [ENTRY_WIDTH-1:0] val);
    list_result_t r;
    int unsigned  room;
    r.read_value = '0;
    r.status = ST_OK;
    room = (s.cap > DEPTH) ? DEPTH : s.cap;
    case (op)
      OP_READ: begin
        if (pos >= s.len) r.status = ST_RANGE;
        else r.read_value = s.mem[pos];
      end
      OP_PUSH: begin
        if (s.len >= room) begin
          r.status = ST_FULL;
        end else begin
          s.mem[s.len] = val;
          s.len++;
        end
      end
      OP_INSERT: begin
        // full wins over a bad index
        if (s.len >= room) begin
          r.status = ST_FULL;
        end else if (pos >= s.len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = s.len; i > pos; i--) s.mem[i] = s.mem[i-1];
          s.mem[pos] = val;
          s.len++;
        end
      end
      default: begin
        if (s.len == 0) begin
          r.status = ST_EMPTY;
        end else if (pos >= s.len) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = pos; i + 1 < s.len; i++) s.mem[i] = s.mem[i+1];
          s.len--;
        end
      end
    endcase
    r.entry_count = s.len[CNT_W-1:0];
    return r;
  endfunction

  task automatic plan_item(op_t op, logic [IDX_W-1:0] pos, logic [ENTRY_WIDTH-1:0] val);
    sched_entry_t e;
    e = '0;
    e.kind = EV_ITEM;
    e.op = op;
    e.pos = pos;
    e.val = val;
    void'(apply_list_op(plan_list, op, pos, val));
    op_schedule.push_back(e);
  endtask

  task automatic plan_cfg(logic [CAP_W-1:0] cap);
    sched_entry_t e;
    e = '0;
    e.kind = EV_CFG;
    e.cap = cap;
    plan_list.cap = cap;
    op_schedule.push_back(e);
  endtask

  task automatic plan_marker(sched_kind_t kind, int spct, int rpct);
    sched_entry_t e;
    e = '0;
    e.kind = kind;
    e.send_pct = spct[6:0];
    e.recv_pct = rpct[6:0];
    op_schedule.push_back(e);
  endtask

  // sender: one item, config write or marker per cycle from the schedule, while no offer is pending
  always @(negedge clk) begin
    sched_entry_t nx;
    logic         offer;
    logic         wr_cfg;
    offer = in_valid && !item_taken;
    wr_cfg = 1'b0;
    if (!rst && !offer && op_schedule.size() > 0) begin
      nx = op_schedule[0];
      case (nx.kind)
        EV_ITEM: begin
          if ($urandom_range(99) >= send_idle_pct) begin
            op_schedule.delete(0);
            operation <= nx.op;
            position <= nx.pos;
            entry_value <= nx.val;
            offer = 1'b1;
          end
        end
        EV_MODE: begin
          op_schedule.delete(0);
          send_idle_pct <= int'(nx.send_pct);
          recv_idle_pct <= int'(nx.recv_pct);
        end
        EV_HOLD: begin
          op_schedule.delete(0);
          hold_reqs <= hold_reqs + 1;
        end
        default: begin
          // config writes and pauses wait for the list to go quiet
          if (awaited_results.size() == 0) begin
            if (settle_left > 0) begin
              settle_left--;
            end else begin
              op_schedule.delete(0);
              settle_left = SETTLE;
              if (nx.kind == EV_CFG) begin
                wr_cfg = 1'b1;
                cfg_wr_data <= nx.cap;
              end
            end
          end else begin
            settle_left = SETTLE;
          end
        end
      endcase
    end
    in_valid <= offer;
    cfg_wr_en <= wr_cfg;
  end

  // receiver: random stalls plus the occasional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_reqs) begin
      hold_seen <= hold_seen + 1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: check results, then update the list copy
  always @(posedge clk) begin
    list_result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no item outstanding");
          mismatch_count++;
        end else begin
          want = awaited_results.pop_front();
          status_seen[want.status]++;
          if (read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, read_value);
            mismatch_count++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d (%s), got %0d", want.status, want.status.name(),
                   status);
            mismatch_count++;
          end
          if (entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
            mismatch_count++;
          end
        end
      end
      if (cfg_wr_en) begin
        live_list.cap = cfg_wr_data;
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        awaited_results.push_back(apply_list_op(live_list, op_t'(operation), position,
                                                entry_value));
        ops_seen[operation]++;
        if (live_list.len > peak_len) peak_len = int'(live_list.len);
      end
    end
    item_taken <= !rst && in_valid && in_ready;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int               phase_caps [9];
    int               n;
    int               r;
    op_t              op;
    logic [IDX_W-1:0] pos;
    logic [31:0]      val;
    bit               grow;

    plan_list.mem = '{default: '0};
    plan_list.len = 0;
    plan_list.cap = CAP_RESET;
    live_list = plan_list;

    // directed: empty list, both ends of the data, each rejection
    plan_marker(EV_MODE, 24, 56);
    plan_item(OP_READ, 6'd0, 32'h0);
    plan_item(OP_DELETE, 6'd5, 32'h0);
    plan_item(OP_INSERT, 6'd0, 32'h1111_1111);
    plan_item(OP_PUSH, 6'd0, 32'h0000_0000);
    plan_item(OP_PUSH, 6'd63, 32'hFFFF_FFFF);
    plan_item(OP_PUSH, 6'd0, 32'hA5A5_A5A5);
    plan_item(OP_READ, 6'd0, 32'hFFFF_FFFF);
    plan_item(OP_READ, 6'd1, 32'h0);
    plan_item(OP_READ, 6'd3, 32'h0);
    plan_item(OP_INSERT, 6'd0, 32'h1234_5678);
    plan_item(OP_INSERT, 6'd3, 32'hDEAD_BEEF);
    plan_item(OP_INSERT, 6'd5, 32'h5A5A_5A5A);
    plan_item(OP_READ, 6'd63, 32'h0);
    plan_item(OP_DELETE, 6'd63, 32'h0);
    plan_item(OP_DELETE, 6'd4, 32'h0);
    plan_item(OP_DELETE, 6'd0, 32'h0);
    plan_item(OP_READ, 6'd2, 32'h0);
    // capacity zero with entries still held
    plan_cfg(7'd0);
    plan_item(OP_PUSH, 6'd0, 32'h7777_7777);
    plan_item(OP_INSERT, 6'd63, 32'h8888_8888);
    plan_item(OP_READ, 6'd0, 32'h0);
    plan_item(OP_DELETE, 6'd1, 32'h0);
    plan_cfg(7'd2);
    plan_item(OP_PUSH, 6'd0, 32'h0F0F_0F0F);
    plan_item(OP_INSERT, 6'd0, 32'hF0F0_F0F0);
    plan_item(OP_DELETE, 6'd0, 32'h0);
    plan_item(OP_PUSH, 6'd0, 32'h3C3C_3C3C);

    // random phases, one capacity setting each
    phase_caps = '{64, 127, 3, 0, 1, 100, 2, 64, 0};
    phase_caps[8] = $urandom_range(0, 127);
    for (int ph = 0; ph < 9; ph++) begin
      if (ph == 3) plan_marker(EV_MODE, 56, 24);
      if (ph == 6) plan_marker(EV_MODE, 0, 0);
      plan_cfg(phase_caps[ph][CAP_W-1:0]);
      n = (ph == 0 || ph == 1 || ph == 7) ? 200 : 140;
      for (int k = 0; k < n; k++) begin
        if (k == n / 2 && (ph == 2 || ph == 6 || ph == 7)) plan_marker(EV_HOLD, 0, 0);
        if (k == n / 2 && ph == 4) plan_marker(EV_DRAIN, 0, 0);
        // fill phases lean on push and insert, second halves lean on delete
        grow = (k < n / 2) && (ph == 0 || ph == 1 || ph == 7);
        r = $urandom_range(99);
        if (grow)
          op = r < 55 ? OP_PUSH : r < 80 ? OP_INSERT : r < 85 ? OP_DELETE : OP_READ;
        else if (k >= n / 2)
          op = r < 20 ? OP_PUSH : r < 40 ? OP_INSERT : r < 75 ? OP_DELETE : OP_READ;
        else
          op = op_t'(r % 4);
        r = $urandom_range(99);
        if (plan_list.len == 0 || r < 8) pos = IDX_W'($urandom_range(0, 63));
        else if (r < 16) pos = plan_list.len[IDX_W-1:0];
        else if (r < 26) pos = '0;
        else if (r < 36) pos = IDX_W'(plan_list.len - 1);
        else pos = IDX_W'($urandom_range(0, plan_list.len - 1));
        r = $urandom_range(99);
        val = r < 5 ? 32'h0 : r < 10 ? 32'hFFFF_FFFF : $urandom;
        plan_item(op, pos, val);
      end
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (op_schedule.size() > 0 || in_valid || awaited_results.size() > 0);
    repeat (4) @(posedge clk);

    $display("ran %0d items: %0d reads, %0d pushes, %0d inserts, %0d deletes",
             ops_seen[0] + ops_seen[1] + ops_seen[2] + ops_seen[3],
             ops_seen[OP_READ], ops_seen[OP_PUSH], ops_seen[OP_INSERT], ops_seen[OP_DELETE]);
    $display("status ok/full/empty/range %0d/%0d/%0d/%0d, longest list %0d, %0d capacity writes",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_RANGE], peak_len, cfg_writes);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
